// ===== src/bcu_pkg.sv =====
`default_nettype none

package bcu_pkg;

  localparam int MAX_WIDTH_DEF = 64;   // widest operand type the unit handles
  localparam int OPERAND_W     = 64;   // operand_value / fallback_value / count
  localparam int OPW_W         = 7;    // operand_width field
  localparam int BL_W          = 7;    // bit length / zero counts, 0..64

  // input beat layout
  localparam int IN_USER_W  = 4;       // op, has_fallback
  localparam int IN_DATA_W  = 136;     // 135 payload bits padded to bytes
  localparam int IN_OPW_LSB = 0;
  localparam int IN_VAL_LSB = IN_OPW_LSB + OPW_W;
  localparam int IN_FB_LSB  = IN_VAL_LSB + OPERAND_W;
  localparam int IN_PAD_W   = IN_DATA_W - (IN_FB_LSB + OPERAND_W);

  // result beat layout
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 1;

  typedef enum logic [2:0] {
    OP_CLZ    = 3'd0,
    OP_CTZ    = 3'd1,
    OP_POPCNT = 3'd2,
    OP_PARITY = 3'd3,
    OP_FFS    = 3'd4,
    OP_CLRSB  = 3'd5
  } op_t;

  typedef struct packed {
    logic signed [OPERAND_W-1:0] fallback_value;
    logic                        has_fallback;
    logic [OPERAND_W-1:0]        operand_value;
    logic [OPW_W-1:0]            operand_width;
    op_t                         op;
  } in_item_t;

  typedef struct packed {
    logic signed [OPERAND_W-1:0] count;
    logic                        status;   // 1: undefined
  } result_t;

  // index of highest set bit plus one, 0 for zero
  function automatic logic [3:0] bitlen8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [BL_W-1:0] bitlen64(input logic [OPERAND_W-1:0] v);
    logic [BL_W-1:0] n;
    n = '0;
    for (int g = 0; g < 8; g++) begin
      if (v[g*8 +: 8] != 8'd0) n = BL_W'(g * 8) + BL_W'(bitlen8(v[g*8 +: 8]));
    end
    return n;
  endfunction

  function automatic logic [3:0] tz8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) n = 4'(i);
    end
    return n;
  endfunction

  // 64 for a zero word
  function automatic logic [BL_W-1:0] tzcnt64(input logic [OPERAND_W-1:0] v);
    logic [BL_W-1:0] n;
    n = BL_W'(OPERAND_W);
    for (int g = 7; g >= 0; g--) begin
      if (v[g*8 +: 8] != 8'd0) n = BL_W'(g * 8) + BL_W'(tz8(v[g*8 +: 8]));
    end
    return n;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  function automatic logic [BL_W-1:0] popcnt64(input logic [OPERAND_W-1:0] v);
    logic [BL_W-1:0] n;
    n = '0;
    for (int g = 0; g < 8; g++) begin
      n = n + BL_W'(pop8(v[g*8 +: 8]));
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== src/bcu_pipe_reg.sv =====
`default_nettype none

// One register stage with valid/ready; ready looks through to the next stage.
module bcu_pipe_reg #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/bcu_calc.sv =====
`default_nettype none

module bcu_calc
  import bcu_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire in_item_t item,
  output result_t       res
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > BL_W) ? WW : BL_W;

  logic [OPW_W-1:0]     w0;
  logic [WW-1:0]        wc;
  logic [OPERAND_W-1:0] mask;
  logic [OPERAND_W-1:0] sel;
  logic [OPERAND_W-1:0] v;
  logic [OPERAND_W-1:0] mag;
  logic [OPERAND_W-1:0] lz_in;
  logic                 zero;
  logic                 sign;
  logic [BL_W-1:0]      bl;
  logic [BL_W-1:0]      tz;
  logic [BL_W-1:0]      pc;
  logic [CW-1:0]        small_cnt;

  // width zero counts as one bit, then clamp to the widest type
  always_comb begin
    w0 = (item.operand_width == '0) ? OPW_W'(1) : item.operand_width;
    if (int'(w0) > MAX_WIDTH) wc = WW'(MAX_WIDTH);
    else                      wc = WW'(w0);
  end

  always_comb begin
    for (int i = 0; i < OPERAND_W; i++) begin
      mask[i] = (i < int'(wc));
      sel[i]  = ((i + 1) == int'(wc));
    end
  end

  assign v     = item.operand_value & mask;
  assign zero  = (v == '0);
  // no sign bit inside the 64 operand bits for wider types
  assign sign  = (int'(wc) <= OPERAND_W) && |(v & sel);
  assign mag   = sign ? (v ^ mask) : v;
  assign lz_in = (item.op == OP_CLRSB) ? mag : v;

  assign bl = bitlen64(lz_in);
  assign tz = tzcnt64(v);
  assign pc = popcnt64(v);

  always_comb begin
    small_cnt  = '0;
    res.status = 1'b0;
    case (item.op)
      OP_CLZ: begin
        if (zero) res.status = 1'b1;
        else      small_cnt  = CW'(wc) - CW'(bl);
      end
      OP_CTZ: begin
        if (zero) res.status = 1'b1;
        else      small_cnt  = CW'(tz);
      end
      OP_POPCNT: small_cnt = CW'(pc);
      OP_PARITY: small_cnt = CW'(pc[0]);
      OP_FFS:    small_cnt = zero ? '0 : CW'(tz) + CW'(1);
      OP_CLRSB:  small_cnt = CW'(wc) - CW'(bl) - CW'(1);
      default:   res.status = 1'b1;
    endcase
    res.count = {{(OPERAND_W - CW){1'b0}}, small_cnt};
    // zero operand with a fallback overrides every op code
    if (zero && item.has_fallback) begin
      res.count  = item.fallback_value;
      res.status = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/bit_count_unit_top.sv =====
// Channel  | Ports        | Fields (lowest bit first)
// ---------+--------------+---------------------------------------------------------
// input    | in_t*        | tuser: op[2:0], has_fallback[3]
//          |              | tdata: operand_width[6:0], operand_value[70:7],
//          |              |        fallback_value[134:71], zero pad [135]
// result   | out_t*       | tdata: count[63:0]   tuser: status[0] (1 = undefined)
//
// A beat passes an input register, then the bit-count logic, then the result
// register. One beat per cycle sustained while out_tready is high.
// Throughput is set by the result register, whose ready looks through to out_tready.
// rst_n is synchronous, active low; it clears the two valid flags only.
// A stalled result holds; the input register keeps taking a beat while it is empty.
`default_nettype none

module bit_count_unit_top
  import bcu_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input beats
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // operand_width, operand_value, fallback_value
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // op, has_fallback
  // result beats
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // count
  output logic [OUT_USER_W-1:0]      out_tuser   // status
);

  in_item_t item_in;
  in_item_t item_q;
  result_t  res_d;
  result_t  res_q;
  logic     s1_valid;
  logic     s1_ready;

  // unpack the input beat
  assign item_in.op             = op_t'(in_tuser[2:0]);
  assign item_in.has_fallback   = in_tuser[3];
  assign item_in.operand_width  = in_tdata[IN_OPW_LSB +: OPW_W];
  assign item_in.operand_value  = in_tdata[IN_VAL_LSB +: OPERAND_W];
  assign item_in.fallback_value = in_tdata[IN_FB_LSB +: OPERAND_W];

  // input register
  bcu_pipe_reg #(
    .W($bits(in_item_t))
  ) u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (item_in),
    .out_valid(s1_valid),
    .out_ready(s1_ready),
    .out_data (item_q)
  );

  // all six counts and the fallback select in one pass
  bcu_calc #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_calc (
    .item(item_q),
    .res (res_d)
  );

  // result register
  bcu_pipe_reg #(
    .W($bits(result_t))
  ) u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid),
    .in_ready (s1_ready),
    .in_data  (res_d),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (res_q)
  );

  assign out_tdata = res_q.count;
  assign out_tuser = res_q.status;

  logic [IN_PAD_W-1:0] unused_pad;
  assign unused_pad = in_tdata[IN_DATA_W-1 -: IN_PAD_W];

endmodule

`default_nettype wire

// ===== src/bcu_checker.sv =====
`default_nettype none

module bcu_checker
  import bcu_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input only stalls when both stages are full and the sink is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled full result");

  // an undefined result always carries a zero count
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("undefined status with nonzero count");

  logic unused_in_valid;
  assign unused_in_valid = in_tvalid;

endmodule

bind bit_count_unit_top bcu_checker u_bcu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire

// ===== tb/bit_count_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the bit-count unit, predicts each result from the
// accepted input beat and compares it with the result beats in order.
module bit_count_checker
  import bcu_pkg::*;
#(
  parameter int MAX_W = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OUT_USER_W-1:0] out_tuser,
  output int                    fail_count,
  output int                    beats_due
);

  result_t counts_due[$];
  result_t want;
  int      errs = 0;

  initial begin
    fail_count = 0;
    beats_due  = 0;
  end

  // index of the highest set bit plus one
  function automatic int msb_len(input logic [63:0] x);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic result_t predict_count(input logic [2:0]  op,
                                            input logic [6:0]  wfield,
                                            input logic [63:0] raw,
                                            input logic        use_fb,
                                            input logic [63:0] fb);
    result_t     r;
    int          w;
    int          tz;
    int          ones;
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    r.count  = '0;
    r.status = 1'b0;
    w = int'(wfield);
    if (w == 0) w = 1;
    else if (w > MAX_W) w = MAX_W;
    mask = (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
    v    = raw & mask;
    tz   = 64;
    ones = 0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) tz = i;
      ones += int'(v[i]);
    end
    if (v == '0 && use_fb) begin
      r.count = fb;
    end else begin
      case (op)
        OP_CLZ: begin
          if (v == '0) r.status = 1'b1;
          else r.count = 64'(w - msb_len(v));
        end
        OP_CTZ: begin
          if (v == '0) r.status = 1'b1;
          else r.count = 64'(tz);
        end
        OP_POPCNT: r.count = 64'(ones);
        OP_PARITY: r.count = 64'(ones & 1);
        OP_FFS:    r.count = (v == '0) ? 64'd0 : 64'(tz + 1);
        OP_CLRSB: begin
          // fold a set sign bit so that redundant sign bits become leading zeros;
          // types wider than 64 bits have no sign bit in the operand
          mag = ((w <= 64) && v[w-1]) ? (v ^ mask) : v;
          r.count = 64'(w - msb_len(mag) - 1);
        end
        default: r.status = 1'b1;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        counts_due = {counts_due, predict_count(in_tuser[2:0],
                                                in_tdata[IN_OPW_LSB +: OPW_W],
                                                in_tdata[IN_VAL_LSB +: OPERAND_W],
                                                in_tuser[3],
                                                in_tdata[IN_FB_LSB +: OPERAND_W])};
      end
      if (out_tvalid && out_tready) begin
        if (counts_due.size() == 0) begin
          $error("result beat with nothing pending: count %0d status %0d",
                 $signed(out_tdata), out_tuser[0]);
          errs++;
        end else begin
          want = counts_due.pop_front();
          if (want.count !== $signed(out_tdata)) begin
            $error("count: expected %0d, actual %0d", want.count, $signed(out_tdata));
            errs++;
          end
          if (want.status !== out_tuser[0]) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser[0]);
            errs++;
          end
        end
      end
      beats_due  <= counts_due.size();
      fail_count <= errs;
    end
  end

endmodule

// ===== tb/bit_count_unit_top_test.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the bit-count unit; results are predicted and compared
// in the checker instance beside the DUT.
module bit_count_unit_top_test;
  import bcu_pkg::*;

  // op codes the unit does not define; they come back undefined unless a zero operand takes its fallback
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam int PHASE_BEATS  = 250;     // 8 random phases, ~2000 beats total
  localparam int HOLD_CYCLES  = 64;      // long receiver hold-off, fills the pipe
  localparam int DRAIN_CYCLES = 8;       // slack before the final verdict
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest clean run

  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // operand_width, operand_value, fallback_value, pad
  logic [IN_USER_W-1:0]  in_tuser   = '0;   // op, has_fallback
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;         // count
  logic [OUT_USER_W-1:0] out_tuser;         // status

  int fail_count;
  int beats_due;

  // traffic knobs; the receiver knobs are written with <= so the receiver
  // process never races the write
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_token   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int cycle_cnt    = 0;

  logic [2:0] all_ops [8] = '{OP_CLZ, OP_CTZ, OP_POPCNT, OP_PARITY,
                              OP_FFS, OP_CLRSB, OP_SPARE6, OP_SPARE7};
  logic [6:0] odd_widths [5] = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127};

  always #6 clk = ~clk;

  bit_count_unit_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  bit_count_checker #(.MAX_W(MAX_WIDTH_DEF)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .beats_due  (beats_due)
  );

  // Hard stop in case the unit locks up.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("bit_count_unit_top_test: done, errors");
      $finish;
    end
  end

  // Result side. A bump of hold_token starts a long hold-off that this
  // process counts down itself; otherwise ready drops at rx_stall_pct.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_token) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // One input beat: optional idle cycles, then hold it until accepted.
  // in_tready is read right after the edge, i.e. its pre-edge value.
  task automatic send_beat(input logic [2:0]  op,
                           input logic [6:0]  w,
                           input logic [63:0] val,
                           input logic        use_fb,
                           input logic [63:0] fb);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {use_fb, op};
    in_tdata  <= {1'b0, fb, val, w};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic rand_beat();
    logic [2:0]  op;
    logic [6:0]  w;
    logic [63:0] val;
    logic [63:0] fb;
    // undefined codes now and then, the six real ops the rest of the time
    op = ($urandom_range(11) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    case ($urandom_range(9))
      0:       w = 7'($urandom_range(127));               // incl. 0 and above max
      1:       w = odd_widths[$urandom_range(4)];
      2:       w = 7'd64;
      default: w = 7'($urandom_range(64, 1));
    endcase
    case ($urandom_range(7))
      0:       val = '0;
      1:       val = 64'd1 << $urandom_range(63);
      2:       val = '1;
      3:       val = ~(64'd1 << $urandom_range(63));
      4:       val = {$urandom, $urandom} >> $urandom_range(63);
      5:       val = {$urandom, $urandom} << $urandom_range(63);   // often zero in width
      default: val = {$urandom, $urandom};
    endcase
    case ($urandom_range(3))
      0:       fb = S64_MIN;
      1:       fb = S64_MAX;
      default: fb = {$urandom, $urandom};
    endcase
    send_beat(op, w, val, 1'($urandom_range(1)), fb);
  endtask

  // Wait until the checker has seen every expected result. The first edge
  // lets the last push show up in beats_due.
  task automatic drain();
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n, input bit hold);
    tx_idle_pct = idle;
    rx_stall_pct <= stall;
    if (hold) hold_token <= hold_token + 1;
    repeat (n) rand_beat();
    in_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every code with a full-width all-ones operand
    foreach (all_ops[k]) send_beat(all_ops[k], 7'd64, '1, 1'b0, 64'd0);
    // every code with a zero operand at an oversize width, fallback on alternate codes
    foreach (all_ops[k])
      send_beat(all_ops[k], 7'd127, 64'd0, k[0], k[1] ? S64_MIN : S64_MAX);
    send_beat(OP_CLZ,    7'd0,   64'd1, 1'b0, 64'd0);          // width zero acts as one
    send_beat(OP_CLZ,    7'd1,   64'd1, 1'b0, 64'd0);
    send_beat(OP_CLRSB,  7'd8,   64'h80, 1'b0, 64'd0);         // sign bit set
    send_beat(OP_CLRSB,  7'd64,  S64_MIN, 1'b0, 64'd0);
    send_beat(OP_CTZ,    7'd64,  S64_MIN, 1'b0, 64'd0);
    send_beat(OP_FFS,    7'd33,  64'hFFFF_FFFE_0000_0000, 1'b0, 64'd0); // truncates to zero
    send_beat(OP_POPCNT, 7'd65,  '1, 1'b1, S64_MAX);           // fallback ignored, nonzero
    in_tvalid <= 1'b0;
    drain();

    // random phases: no idling, sender idle, receiver stall, both;
    // the fifth adds a long receiver hold-off while the sender keeps pushing
    run_phase(0,  0,  PHASE_BEATS, 1'b0);
    run_phase(46, 0,  PHASE_BEATS, 1'b0);
    run_phase(0,  46, PHASE_BEATS, 1'b0);
    run_phase(18, 18, PHASE_BEATS, 1'b0);
    run_phase(0,  0,  PHASE_BEATS, 1'b1);
    run_phase(46, 0,  PHASE_BEATS, 1'b0);
    run_phase(0,  46, PHASE_BEATS, 1'b0);
    run_phase(18, 18, PHASE_BEATS, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && beats_due == 0) begin
      $display("bit_count_unit_top_test: done, clean");
    end else begin
      $display("bit_count_unit_top_test: done, errors");
    end
    $finish;
  end

endmodule
